@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker nfc_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/nfc_pkg.sv @@
// Types and constants of the flow cache.
// Used by nfc_ctrl, nfc_dp and netflow_flow_cache.
package nfc_pkg;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  FLAG_CLOSE = 8'h05;  // FIN | RST
  localparam int          MS_PER_S   = 1000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXF     = 2'd2;

  localparam logic [11:0] ACT_RST   = 12'd60;
  localparam logic [11:0] INACT_RST = 12'd10;
  localparam logic [5:0]  MAXF_RST  = 6'd32;

  localparam int KEY_W = 104;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [7:0]  flags;
    logic [31:0] packets;
    logic [31:0] octets;
    logic [31:0] first_ms;
    logic [31:0] last_ms;
  } flow_t;

  typedef enum logic [1:0] {SM_OLD, SM_MARK, SM_KEY, SM_MATCH} scan_mode_t;
  typedef enum logic [1:0] {PH_EVICT, PH_SWEEP, PH_CLOSE} phase_t;
  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_DECIDE, S_EMIT_RD, S_EMIT_LD, S_WRITE, S_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       prep;
    logic       scan_clr;
    logic       scan_eval;
    scan_mode_t mode;
    logic       write;
    logic       emit_rd;
    logic       emit_ld;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic is_flush;
    logic drop;
    logic need_evict;
    logic found;
    logic closes;
    logic out_free;
  } sts_t;

  function automatic logic [KEY_W-1:0] flow_key(input flow_t f);
    return {f.src_addr, f.dst_addr, f.src_port, f.dst_port, f.protocol};
  endfunction

endpackage

@@ rtl/netflow_flow_cache.sv @@
// Top level of the five-tuple flow cache.
// Depends on nfc_pkg, nfc_ctrl and nfc_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, time, header fields
//  out     | out_valid / out_ready| exported flow, out_last_of_run
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_wdata (12 bit)
//
// One item at a time. Every table scan reads all CACHE_DEPTH entries,
// one per cycle, from the table's single read port. A packet takes an
// eviction scan when full, one mark scan, one key scan per timed-out
// flow plus one, and a match scan; each export adds a table read and a
// load into the hold stage. A flush takes one key scan per cached flow
// plus one; a dropped packet takes no scan. Reset clears the valid bits;
// there is no clearing pass. A stalled out channel holds the sequencer
// at its next export or at the end of the item.
module netflow_flow_cache #(
  parameter int CACHE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [31:0]                    in_time_ms,
  input  logic [15:0]                    in_eth_type,
  input  logic [31:0]                    in_src_addr,
  input  logic [31:0]                    in_dst_addr,
  input  logic [7:0]                     in_protocol,
  input  logic [7:0]                     in_tos,
  input  logic [15:0]                    in_ip_length,
  input  logic [15:0]                    in_src_port,
  input  logic [15:0]                    in_dst_port,
  input  logic [7:0]                     in_tcp_flag_bits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_src_addr,
  output logic [31:0]                    out_dst_addr,
  output logic [15:0]                    out_src_port,
  output logic [15:0]                    out_dst_port,
  output logic [7:0]                     out_protocol,
  output logic [7:0]                     out_tos,
  output logic [7:0]                     out_flags,
  output logic [31:0]                    out_packets,
  output logic [31:0]                    out_octets,
  output logic [31:0]                    out_first_ms,
  output logic [31:0]                    out_last_ms,
  output logic                           out_last_of_run
);

  // table index width and a counter wide enough to reach the depth
  localparam int IW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);

  nfc_pkg::cmd_t  cmd;
  nfc_pkg::sts_t  sts;
  nfc_pkg::flow_t out_flow;
  logic [IW-1:0]  scan_addr;

  nfc_ctrl #(.DEPTH(CACHE_DEPTH), .IW(IW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  nfc_dp #(.DEPTH(CACHE_DEPTH), .IW(IW), .CW(CW)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_action),
    .in_time_ms       (in_time_ms),
    .in_eth_type      (in_eth_type),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_protocol      (in_protocol),
    .in_tos           (in_tos),
    .in_ip_length     (in_ip_length),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_tcp_flag_bits (in_tcp_flag_bits),
    .cmd              (cmd),
    .scan_addr        (scan_addr),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_flow         (out_flow),
    .out_last         (out_last_of_run)
  );

  // flatten the exported record onto the result ports
  assign out_src_addr = out_flow.src_addr;
  assign out_dst_addr = out_flow.dst_addr;
  assign out_src_port = out_flow.src_port;
  assign out_dst_port = out_flow.dst_port;
  assign out_protocol = out_flow.protocol;
  assign out_tos      = out_flow.tos;
  assign out_flags    = out_flow.flags;
  assign out_packets  = out_flow.packets;
  assign out_octets   = out_flow.octets;
  assign out_first_ms = out_flow.first_ms;
  assign out_last_ms  = out_flow.last_ms;

endmodule

@@ rtl/nfc_ctrl.sv @@
// Sequencer of the flow cache: scans, exports and the table update.
// Depends on nfc_pkg.
module nfc_ctrl #(
  parameter int DEPTH = 32,
  parameter int IW    = 5,
  parameter int CW    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nfc_pkg::sts_t     sts,
  output nfc_pkg::cmd_t     cmd,
  output logic [IW-1:0]     scan_addr
);

  nfc_pkg::state_t     state_r, state_nxt;
  nfc_pkg::scan_mode_t mode_r, mode_nxt;
  nfc_pkg::phase_t     phase_r, phase_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  assign scan_addr = cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfc_pkg::S_IDLE;
      mode_r  <= nfc_pkg::SM_OLD;
      phase_r <= nfc_pkg::PH_EVICT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mode  = mode_r;
    case (state_r)
      nfc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = nfc_pkg::S_PREP;
        end
      end
      nfc_pkg::S_PREP: begin
        cmd.prep     = 1'b1;
        cmd.scan_clr = 1'b1;
        cnt_nxt      = '0;
        if (sts.is_flush) begin
          phase_nxt = nfc_pkg::PH_SWEEP;
          mode_nxt  = nfc_pkg::SM_KEY;
          state_nxt = nfc_pkg::S_SCAN;
        end else if (sts.drop) begin
          state_nxt = nfc_pkg::S_FINISH;
        end else if (sts.need_evict) begin
          mode_nxt  = nfc_pkg::SM_OLD;
          state_nxt = nfc_pkg::S_SCAN;
        end else begin
          mode_nxt  = nfc_pkg::SM_MARK;
          state_nxt = nfc_pkg::S_SCAN;
        end
      end
      nfc_pkg::S_SCAN: begin
        // read issued at cnt, evaluated in the following cycle
        cmd.scan_eval = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(DEPTH)) begin
          state_nxt = nfc_pkg::S_DECIDE;
        end
      end
      nfc_pkg::S_DECIDE: begin
        cnt_nxt = '0;
        case (mode_r)
          nfc_pkg::SM_OLD: begin
            if (sts.found) begin
              phase_nxt = nfc_pkg::PH_EVICT;
              state_nxt = nfc_pkg::S_EMIT_RD;
            end else begin
              cmd.scan_clr = 1'b1;
              mode_nxt     = nfc_pkg::SM_MARK;
              state_nxt    = nfc_pkg::S_SCAN;
            end
          end
          nfc_pkg::SM_MARK: begin
            cmd.scan_clr = 1'b1;
            phase_nxt    = nfc_pkg::PH_SWEEP;
            mode_nxt     = nfc_pkg::SM_KEY;
            state_nxt    = nfc_pkg::S_SCAN;
          end
          nfc_pkg::SM_KEY: begin
            if (sts.found) begin
              phase_nxt = nfc_pkg::PH_SWEEP;
              state_nxt = nfc_pkg::S_EMIT_RD;
            end else if (sts.is_flush) begin
              state_nxt = nfc_pkg::S_FINISH;
            end else begin
              cmd.scan_clr = 1'b1;
              mode_nxt     = nfc_pkg::SM_MATCH;
              state_nxt    = nfc_pkg::S_SCAN;
            end
          end
          default: begin
            state_nxt = nfc_pkg::S_WRITE;
          end
        endcase
      end
      nfc_pkg::S_WRITE: begin
        cmd.write = 1'b1;
        if (sts.closes) begin
          phase_nxt = nfc_pkg::PH_CLOSE;
          state_nxt = nfc_pkg::S_EMIT_RD;
        end else begin
          state_nxt = nfc_pkg::S_FINISH;
        end
      end
      nfc_pkg::S_EMIT_RD: begin
        if (sts.out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = nfc_pkg::S_EMIT_LD;
        end
      end
      nfc_pkg::S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        cnt_nxt     = '0;
        case (phase_r)
          nfc_pkg::PH_EVICT: begin
            cmd.scan_clr = 1'b1;
            mode_nxt     = nfc_pkg::SM_MARK;
            state_nxt    = nfc_pkg::S_SCAN;
          end
          nfc_pkg::PH_SWEEP: begin
            cmd.scan_clr = 1'b1;
            mode_nxt     = nfc_pkg::SM_KEY;
            state_nxt    = nfc_pkg::S_SCAN;
          end
          default: begin
            state_nxt = nfc_pkg::S_FINISH;
          end
        endcase
      end
      nfc_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = nfc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = nfc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/nfc_dp.sv @@
// Datapath of the flow cache: flow table, valid and mark bits, scan
// compare, timeout logic, hold and output registers. Depends on nfc_pkg.
module nfc_dp #(
  parameter int DEPTH = 32,
  parameter int IW    = 5,
  parameter int CW    = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_action,
  input  logic [31:0]                    in_time_ms,
  input  logic [15:0]                    in_eth_type,
  input  logic [31:0]                    in_src_addr,
  input  logic [31:0]                    in_dst_addr,
  input  logic [7:0]                     in_protocol,
  input  logic [7:0]                     in_tos,
  input  logic [15:0]                    in_ip_length,
  input  logic [15:0]                    in_src_port,
  input  logic [15:0]                    in_dst_port,
  input  logic [7:0]                     in_tcp_flag_bits,
  input  nfc_pkg::cmd_t                  cmd,
  input  logic [IW-1:0]                  scan_addr,
  output nfc_pkg::sts_t                  sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output nfc_pkg::flow_t                 out_flow,
  output logic                           out_last
);

  // configuration
  logic [11:0] act_r, inact_r;
  logic [5:0]  maxf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= nfc_pkg::ACT_RST;
      inact_r <= nfc_pkg::INACT_RST;
      maxf_r  <= nfc_pkg::MAXF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nfc_pkg::CFG_ACTIVE:   act_r   <= cfg_wdata;
        nfc_pkg::CFG_INACTIVE: inact_r <= cfg_wdata;
        nfc_pkg::CFG_MAXF:     maxf_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        p_action_r;
  logic [31:0] p_time_r, p_src_r, p_dst_r;
  logic [15:0] p_ether_r, p_len_r, p_sp_r, p_dp_r;
  logic [7:0]  p_proto_r, p_tos_r, p_tcpf_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_action_r <= in_action;
      p_time_r   <= in_time_ms;
      p_ether_r  <= in_eth_type;
      p_src_r    <= in_src_addr;
      p_dst_r    <= in_dst_addr;
      p_proto_r  <= in_protocol;
      p_tos_r    <= in_tos;
      p_len_r    <= in_ip_length;
      p_sp_r     <= in_src_port;
      p_dp_r     <= in_dst_port;
      p_tcpf_r   <= in_tcp_flag_bits;
    end
  end

  // uptime and timeouts in ms
  logic [31:0] origin_r, up_r, act_ms_r, inact_ms_r;
  logic        seen_r;

  logic                       pkt_drop, pkt_icmp;
  logic [7:0]                 pkt_flags;
  nfc_pkg::flow_t             pkt_new;
  logic [nfc_pkg::KEY_W-1:0]  pkt_key;

  always_comb begin
    pkt_drop  = (p_ether_r != nfc_pkg::ETH_IPV4) ||
                !(p_proto_r inside {nfc_pkg::PROTO_ICMP, nfc_pkg::PROTO_TCP,
                                    nfc_pkg::PROTO_UDP});
    pkt_icmp  = (p_proto_r == nfc_pkg::PROTO_ICMP);
    pkt_flags = (p_proto_r == nfc_pkg::PROTO_TCP) ? p_tcpf_r : 8'd0;
    pkt_new.src_addr = p_src_r;
    pkt_new.dst_addr = p_dst_r;
    pkt_new.src_port = pkt_icmp ? 16'd0 : p_sp_r;
    pkt_new.dst_port = pkt_icmp ? 16'd0 : p_dp_r;
    pkt_new.protocol = p_proto_r;
    pkt_new.tos      = p_tos_r;
    pkt_new.flags    = pkt_flags;
    pkt_new.packets  = 32'd1;
    pkt_new.octets   = {16'd0, p_len_r};
    pkt_new.first_ms = up_r;
    pkt_new.last_ms  = up_r;
    pkt_key = nfc_pkg::flow_key(pkt_new);
  end

  // table
  nfc_pkg::flow_t mem [DEPTH];
  nfc_pkg::flow_t rdata_r;
  logic [IW-1:0]  rd_addr, idx_d_r, wr_addr;
  logic           wr_en;
  nfc_pkg::flow_t wr_data;
  logic [IW-1:0]  best_idx_r;

  assign rd_addr = cmd.emit_rd ? best_idx_r : scan_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
    idx_d_r <= scan_addr;
  end

  logic [DEPTH-1:0]           valid_r, mark_r;
  logic [CW-1:0]              occ_r, limit;
  logic                       found_r;
  logic [31:0]                best_first_r;
  logic [nfc_pkg::KEY_W-1:0]  best_key_r, cur_key;
  nfc_pkg::flow_t             upd;
  logic                       free_ok;
  logic [IW-1:0]              free_idx;
  logic                       tmo;

  // lowest free slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    if ({1'b0, maxf_r} > 7'(DEPTH)) limit = CW'(DEPTH);
    else if (maxf_r == 6'd0)         limit = CW'(1);
    else                             limit = CW'(maxf_r);
  end

  assign cur_key = nfc_pkg::flow_key(rdata_r);
  assign tmo = ((up_r - rdata_r.first_ms) > act_ms_r) ||
               ((up_r - rdata_r.last_ms) > inact_ms_r);

  // update of the matched entry, held in upd_r
  nfc_pkg::flow_t upd_r;
  always_comb begin
    upd         = upd_r;
    upd.packets = upd_r.packets + 32'd1;
    upd.octets  = upd_r.octets + {16'd0, p_len_r};
    upd.flags   = upd_r.flags | pkt_flags;
    upd.last_ms = up_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx_r;
    wr_data = upd;
    if (cmd.write) begin
      if (found_r) begin
        wr_en = 1'b1;
      end else if (free_ok) begin
        wr_en   = 1'b1;
        wr_addr = free_idx;
        wr_data = pkt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      valid_r <= '0;
      mark_r  <= '0;
      occ_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.prep) begin
        if (p_action_r) begin
          mark_r <= valid_r;
        end else if (!pkt_drop && !seen_r) begin
          seen_r <= 1'b1;
        end
      end
      if (cmd.scan_clr) begin
        found_r <= 1'b0;
      end
      if (cmd.scan_eval) begin
        case (cmd.mode)
          nfc_pkg::SM_OLD: begin
            if (valid_r[idx_d_r] && (!found_r || rdata_r.first_ms < best_first_r ||
                (rdata_r.first_ms == best_first_r && cur_key < best_key_r))) begin
              found_r <= 1'b1;
            end
          end
          nfc_pkg::SM_MARK: begin
            mark_r[idx_d_r] <= valid_r[idx_d_r] && tmo;
          end
          nfc_pkg::SM_KEY: begin
            if (mark_r[idx_d_r] && (!found_r || cur_key < best_key_r)) begin
              found_r <= 1'b1;
            end
          end
          default: begin
            if (valid_r[idx_d_r] && cur_key == pkt_key) begin
              found_r <= 1'b1;
            end
          end
        endcase
      end
      if (cmd.write && !found_r && free_ok) begin
        valid_r[free_idx] <= 1'b1;
        occ_r             <= occ_r + 1'b1;
        found_r           <= 1'b1;
      end
      if (cmd.emit_ld) begin
        valid_r[best_idx_r] <= 1'b0;
        mark_r[best_idx_r]  <= 1'b0;
        occ_r               <= occ_r - 1'b1;
      end
    end
  end

  // payload side of the scans
  always_ff @(posedge clk) begin
    if (cmd.prep && !p_action_r && !pkt_drop) begin
      if (!seen_r) begin
        origin_r <= p_time_r;
        up_r     <= 32'd0;
      end else begin
        up_r <= p_time_r - origin_r;
      end
      act_ms_r   <= 32'(22'(act_r) * 22'(nfc_pkg::MS_PER_S));
      inact_ms_r <= 32'(22'(inact_r) * 22'(nfc_pkg::MS_PER_S));
    end
    if (cmd.scan_eval) begin
      case (cmd.mode)
        nfc_pkg::SM_OLD: begin
          if (valid_r[idx_d_r] && (!found_r || rdata_r.first_ms < best_first_r ||
              (rdata_r.first_ms == best_first_r && cur_key < best_key_r))) begin
            best_idx_r   <= idx_d_r;
            best_first_r <= rdata_r.first_ms;
            best_key_r   <= cur_key;
          end
        end
        nfc_pkg::SM_KEY: begin
          if (mark_r[idx_d_r] && (!found_r || cur_key < best_key_r)) begin
            best_idx_r <= idx_d_r;
            best_key_r <= cur_key;
          end
        end
        nfc_pkg::SM_MATCH: begin
          if (valid_r[idx_d_r] && cur_key == pkt_key) begin
            best_idx_r <= idx_d_r;
            upd_r      <= rdata_r;
          end
        end
        default: ;
      endcase
    end
    if (cmd.write && !found_r && free_ok) begin
      best_idx_r <= free_idx;
    end
  end

  // hold stage: the newest export waits here until it is known whether
  // another one follows, which settles last_of_run
  nfc_pkg::flow_t hold_r;
  logic           hold_v_r, out_v_r, out_last_r;
  nfc_pkg::flow_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.emit_ld) begin
        hold_v_r <= 1'b1;
        if (hold_v_r) begin
          out_v_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        hold_v_r <= 1'b0;
        if (hold_v_r) begin
          out_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      hold_r     <= rdata_r;
      out_r      <= hold_r;
      out_last_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_r      <= hold_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_flow  = out_r;
  assign out_last  = out_last_r;

  always_comb begin
    sts.is_flush   = p_action_r;
    sts.drop       = pkt_drop;
    sts.need_evict = (occ_r >= limit);
    sts.found      = found_r;
    sts.closes     = (found_r || free_ok) && ((pkt_flags & nfc_pkg::FLAG_CLOSE) != 8'd0);
    sts.out_free   = !out_v_r;
  end

endmodule

@@ rtl/nfc_checker.sv @@
// Port-level checks of the flow cache, bound to the top level.
// Depends on assert_macros.svh, nfc_pkg and netflow_flow_cache.
`include "assert_macros.svh"

module nfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_src_addr,
  input logic [15:0] out_src_port,
  input logic [15:0] out_dst_port,
  input logic [7:0]  out_protocol,
  input logic [31:0] out_packets
);

  // a stalled export holds its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(out_src_addr) && $stable(out_packets))

  // leaving reset: nothing to export, ready for an item
  `ASSERT_IMPL(a_reset_idle, clk, rst_n, $past(!rst_n), !out_valid && in_ready)

  // one item at a time: busy right after a transfer in
  `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

  // ICMP flows carry zero ports
  `ASSERT_IMPL(a_icmp_ports, clk, rst_n, out_valid && out_protocol == nfc_pkg::PROTO_ICMP,
               out_src_port == 16'd0 && out_dst_port == 16'd0)

endmodule

bind netflow_flow_cache nfc_checker u_nfc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_src_addr (out_src_addr),
  .out_src_port (out_src_port),
  .out_dst_port (out_dst_port),
  .out_protocol (out_protocol),
  .out_packets  (out_packets)
);

@@ sim/netflow_flow_cache_tb.sv @@
// Self-checking testbench for the five-tuple flow cache netflow_flow_cache.
// Depends on nfc_pkg and the flow cache RTL; a behavioral flow table predicts
// every export, and each out transfer is compared field by field.
`timescale 1ns / 1ps

module netflow_flow_cache_tb;
  import nfc_pkg::*;

  localparam int CACHE_DEPTH = 32;
  localparam int LIMIT_CYCLES = 2000000;
  // Room for a packet that exports nothing: up to three full scans.
  localparam int SETTLE_CYCLES = 6 * (CACHE_DEPTH + 2) + 20;
  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [7:0] PROTO_OTHER = 8'd2;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic ACT_PKT = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // One input transfer; n_exports < 0 means the predictor alone decides.
  typedef struct {
    logic        action;
    logic [31:0] time_ms;
    logic [15:0] eth_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [15:0] ip_length;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flags;
    int          n_exports;
  } pkt_t;

  typedef struct {
    flow_t flow;
    logic  last;
  } export_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [31:0] in_time_ms = '0;
  logic [15:0] in_eth_type = '0;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [7:0] in_protocol = '0;
  logic [7:0] in_tos = '0;
  logic [15:0] in_ip_length = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [7:0] in_tcp_flag_bits = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_src_addr, out_dst_addr;
  logic [15:0] out_src_port, out_dst_port;
  logic [7:0] out_protocol, out_tos, out_flags;
  logic [31:0] out_packets, out_octets, out_first_ms, out_last_ms;
  logic out_last_of_run;

  netflow_flow_cache #(.CACHE_DEPTH(CACHE_DEPTH)) i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_action, .in_time_ms, .in_eth_type,
    .in_src_addr, .in_dst_addr, .in_protocol, .in_tos, .in_ip_length,
    .in_src_port, .in_dst_port, .in_tcp_flag_bits,
    .out_valid, .out_ready, .out_src_addr, .out_dst_addr, .out_src_port,
    .out_dst_port, .out_protocol, .out_tos, .out_flags, .out_packets,
    .out_octets, .out_first_ms, .out_last_ms, .out_last_of_run
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Flow table predictor
  // ---------------------------------------------------------------------
  flow_t flow_tab[CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] flow_live = '0;
  logic [31:0] origin_ms = '0;
  logic origin_set = 1'b0;
  logic [11:0] active_s = ACT_RST;
  logic [11:0] inactive_s = INACT_RST;
  logic [5:0] max_flows = MAXF_RST;

  export_t pending_exports[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;   // no idling on either side in the closing phase

  function automatic logic [103:0] flow_id(int s);
    return {flow_tab[s].src_addr, flow_tab[s].dst_addr, flow_tab[s].src_port,
            flow_tab[s].dst_port, flow_tab[s].protocol};
  endfunction

  task automatic export_slot(int s);
    export_t e;
    e.flow = flow_tab[s];
    e.last = 1'b0;
    pending_exports.insert(pending_exports.size(), e);
    flow_live[s] = 1'b0;
  endtask

  // Marked flows leave in ascending key order.
  task automatic export_in_key_order(logic [CACHE_DEPTH-1:0] mark, inout int n);
    int best;
    forever begin
      best = -1;
      for (int i = 0; i < CACHE_DEPTH; i++)
        if (mark[i] && (best < 0 || flow_id(i) < flow_id(best))) best = i;
      if (best < 0) break;
      mark[best] = 1'b0;
      export_slot(best);
      n++;
    end
  endtask

  task automatic predict_exports(pkt_t p, output int n);
    logic [CACHE_DEPTH-1:0] mark;
    logic [31:0] up, act_ms, inact_ms;
    logic [15:0] sp, dp;
    logic [7:0] fl;
    logic [103:0] id;
    int limit, best, slot;
    n = 0;
    if (p.action == ACT_FLUSH) begin
      export_in_key_order(flow_live, n);
    end else if (p.eth_type == ETH_IPV4 && (p.protocol == PROTO_ICMP ||
                 p.protocol == PROTO_TCP || p.protocol == PROTO_UDP)) begin
      if (!origin_set) begin
        origin_ms = p.time_ms;
        origin_set = 1'b1;
      end
      up = p.time_ms - origin_ms;
      // full cache: oldest first time goes, smallest key on a tie
      limit = (max_flows == 0) ? 1 : (max_flows > CACHE_DEPTH) ? CACHE_DEPTH : max_flows;
      if ($countones(flow_live) >= limit) begin
        best = -1;
        for (int i = 0; i < CACHE_DEPTH; i++)
          if (flow_live[i] && (best < 0 || flow_tab[i].first_ms < flow_tab[best].first_ms ||
              (flow_tab[i].first_ms == flow_tab[best].first_ms &&
               flow_id(i) < flow_id(best))))
            best = i;
        if (best >= 0) begin
          export_slot(best);
          n++;
        end
      end
      // timeouts; ages wrap, so a flow "in the future" reads as ancient
      act_ms = 32'(active_s) * 32'd1000;
      inact_ms = 32'(inactive_s) * 32'd1000;
      for (int i = 0; i < CACHE_DEPTH; i++)
        mark[i] = flow_live[i] && ((32'(up - flow_tab[i].first_ms) > act_ms) ||
                                   (32'(up - flow_tab[i].last_ms) > inact_ms));
      export_in_key_order(mark, n);
      // ICMP has no ports, only TCP carries flags
      sp = (p.protocol == PROTO_ICMP) ? 16'h0 : p.src_port;
      dp = (p.protocol == PROTO_ICMP) ? 16'h0 : p.dst_port;
      fl = (p.protocol == PROTO_TCP) ? p.flags : 8'h0;
      id = {p.src_addr, p.dst_addr, sp, dp, p.protocol};
      slot = -1;
      for (int i = 0; i < CACHE_DEPTH; i++)
        if (slot < 0 && flow_live[i] && flow_id(i) == id) slot = i;
      if (slot >= 0) begin
        flow_tab[slot].packets += 32'd1;
        flow_tab[slot].octets += 32'(p.ip_length);
        flow_tab[slot].flags |= fl;
        flow_tab[slot].last_ms = up;
      end else begin
        for (int i = 0; i < CACHE_DEPTH; i++)
          if (slot < 0 && !flow_live[i]) slot = i;
        if (slot >= 0) begin
          flow_live[slot] = 1'b1;
          flow_tab[slot] = '{p.src_addr, p.dst_addr, sp, dp, p.protocol, p.tos, fl,
                             32'd1, 32'(p.ip_length), up, up};
        end
      end
      if (slot >= 0 && (fl & FLAG_CLOSE) != 8'h0) begin
        export_slot(slot);
        n++;
      end
    end
    if (n > 0) pending_exports[pending_exports.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Result checking: every out transfer against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    export_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_exports.size() == 0) begin
        $display("%0t: unexpected export, expected none, actual src %h dst %h",
                 $time, out_src_addr, out_dst_addr);
        errors++;
      end else begin
        e = pending_exports.pop_front();
        check_field("src_addr", e.flow.src_addr, out_src_addr);
        check_field("dst_addr", e.flow.dst_addr, out_dst_addr);
        check_field("src_port", 32'(e.flow.src_port), 32'(out_src_port));
        check_field("dst_port", 32'(e.flow.dst_port), 32'(out_dst_port));
        check_field("protocol", 32'(e.flow.protocol), 32'(out_protocol));
        check_field("tos", 32'(e.flow.tos), 32'(out_tos));
        check_field("flags", 32'(e.flow.flags), 32'(out_flags));
        check_field("packets", e.flow.packets, out_packets);
        check_field("octets", e.flow.octets, out_octets);
        check_field("first_ms", e.flow.first_ms, out_first_ms);
        check_field("last_ms", e.flow.last_ms, out_last_ms);
        check_field("last_of_run", 32'(e.last), 32'(out_last_of_run));
      end
    end
  end

  // Receiver: stalls in random bursts, none in the quiet phase.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Entered at a falling edge, left at the falling edge after the transfer.
  task automatic send_pkt(pkt_t p);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= p.action;
    in_time_ms <= p.time_ms;
    in_eth_type <= p.eth_type;
    in_src_addr <= p.src_addr;
    in_dst_addr <= p.dst_addr;
    in_protocol <= p.protocol;
    in_tos <= p.tos;
    in_ip_length <= p.ip_length;
    in_src_port <= p.src_port;
    in_dst_port <= p.dst_port;
    in_tcp_flag_bits <= p.flags;
    do @(posedge clk); while (!in_ready);
    predict_exports(p, n);
    if (p.n_exports >= 0 && n != p.n_exports) begin
      $display("%0t: export count mismatch, expected %0d, actual %0d",
               $time, p.n_exports, n);
      errors++;
    end
    @(negedge clk);
  endtask

  // Block idle: all exports seen, then room for a silent item to finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_exports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(logic [11:0] act, logic [11:0] inact, logic [11:0] maxf);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACTIVE;   cfg_wdata <= act;   @(negedge clk);
    cfg_index <= CFG_INACTIVE; cfg_wdata <= inact; @(negedge clk);
    cfg_index <= CFG_MAXF;     cfg_wdata <= maxf;  @(negedge clk);
    cfg_index <= CFG_SPARE;    cfg_wdata <= 12'($urandom); @(negedge clk);
    cfg_we <= 1'b0;
    active_s = act;
    inactive_s = inact;
    max_flows = maxf[5:0];
    @(negedge clk);
  endtask

  // Directed rows, default register values. Counts typed in where obvious.
  pkt_t directed[] = '{
    // first packet fixes the origin; SYN then ACK on the same flow
    '{ACT_PKT, 32'd1000, ETH_IPV4, 32'h0A000001, 32'h0A000002, PROTO_TCP, 8'h00,
      16'd60, 16'd1234, 16'd80, 8'h02, 0},
    '{ACT_PKT, 32'd1500, ETH_IPV4, 32'h0A000001, 32'h0A000002, PROTO_TCP, 8'h10,
      16'd1500, 16'd1234, 16'd80, 8'h10, 0},
    // UDP flags ignored, ICMP ports ignored
    '{ACT_PKT, 32'd2000, ETH_IPV4, 32'hC0A80001, 32'h08080808, PROTO_UDP, 8'h28,
      16'd80, 16'd5353, 16'd53, 8'hFF, 0},
    '{ACT_PKT, 32'd2100, ETH_IPV4, 32'hC0A80002, 32'h08080404, PROTO_ICMP, 8'h00,
      16'd84, 16'hFFFF, 16'hFFFF, 8'hFF, 0},
    // dropped: not IPv4, unknown protocols
    '{ACT_PKT, 32'd2200, ETH_IPV6, 32'h01020304, 32'h05060708, PROTO_TCP, 8'h00,
      16'd40, 16'd1, 16'd2, 8'h01, 0},
    '{ACT_PKT, 32'd2200, ETH_IPV4, 32'h01020304, 32'h05060708, PROTO_OTHER, 8'h00,
      16'd40, 16'd1, 16'd2, 8'h01, 0},
    '{ACT_PKT, 32'd2200, ETH_IPV4, 32'h01020304, 32'h05060708, 8'hFF, 8'h00,
      16'd40, 16'd1, 16'd2, 8'h04, 0},
    // FIN closes the first flow
    '{ACT_PKT, 32'd2500, ETH_IPV4, 32'h0A000001, 32'h0A000002, PROTO_TCP, 8'h00,
      16'd40, 16'd1234, 16'd80, 8'h11, 1},
    // all-ones extremes with RST
    '{ACT_PKT, 32'd2600, ETH_IPV4, 32'hFFFFFFFF, 32'hFFFFFFFF, PROTO_TCP, 8'hFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h04, 1},
    // all-zero extremes
    '{ACT_PKT, 32'd3000, ETH_IPV4, 32'h0, 32'h0, PROTO_TCP, 8'h00,
      16'h0, 16'h0, 16'h0, 8'h00, 0},
    // 19 s later: UDP, ICMP and zero flows idle past 10 s
    '{ACT_PKT, 32'd20000, ETH_IPV4, 32'h0B000001, 32'h0B000002, PROTO_TCP, 8'h01,
      16'd100, 16'd7, 16'd8, 8'hFA, 3},
    '{ACT_PKT, 32'd20500, ETH_IPV4, 32'h0B000001, 32'h0B000002, PROTO_TCP, 8'h00,
      16'd100, 16'd7, 16'd8, 8'h08, 0},
    // time goes backwards: existing flow looks ancient
    '{ACT_PKT, 32'd100, ETH_IPV4, 32'h0C000001, 32'h0C000002, PROTO_UDP, 8'h00,
      16'd200, 16'd9, 16'd10, 8'h00, 1},
    '{ACT_PKT, 32'd150, ETH_IPV4, 32'h0C000003, 32'h0C000004, PROTO_ICMP, 8'h00,
      16'd200, 16'd9, 16'd10, 8'h00, 0},
    '{ACT_FLUSH, 32'd0, 16'h0, 32'h0, 32'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0, 8'h0, 2},
    // empty flush
    '{ACT_FLUSH, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0},
    // wrapped timestamp, then flush
    '{ACT_PKT, 32'hFFFFFFFF, ETH_IPV4, 32'h0D000001, 32'h0D000002, PROTO_TCP, 8'h55,
      16'd1, 16'd11, 16'd12, 8'h02, -1},
    '{ACT_FLUSH, 32'd0, 16'h0, 32'h0, 32'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0, 8'h0, -1}
  };

  // act, inactive, max_flows per random phase; the last one runs without idling
  logic [11:0] phase_regs[6][3] = '{
    '{12'd60, 12'd10, 12'd32},
    '{12'd0, 12'd0, 12'd0},
    '{12'd3600, 12'd1, 12'd1},
    '{12'd5, 12'd2, 12'hFC8},
    '{12'd4095, 12'd4095, 12'd4095},
    '{12'd3600, 12'd3600, 12'd32}
  };

  initial begin
    pkt_t p;
    logic [31:0] now;
    logic [31:0] pool_sa[40], pool_da[40];
    logic [15:0] pool_sp[40], pool_dp[40];
    logic [7:0] pool_pr[40];
    int pool_n, k;
    logic [7:0] protos[3] = '{PROTO_ICMP, PROTO_TCP, PROTO_UDP};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_pkt(directed[i]);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 5) quiet = 1'b1;
      write_regs(phase_regs[ph][0], phase_regs[ph][1], phase_regs[ph][2]);
      // the last two phases, both with a deep cache, draw from 40 flows instead of 8
      pool_n = (ph == 5 || ph == 4) ? 40 : 8;
      for (int j = 0; j < 40; j++) begin
        pool_sa[j] = $urandom;
        pool_da[j] = $urandom;
        pool_sp[j] = 16'($urandom);
        pool_dp[j] = 16'($urandom);
        pool_pr[j] = protos[$urandom_range(0, 2)];
      end
      now = $urandom;
      for (int it = 0; it < 35; it++) begin
        k = $urandom_range(0, pool_n - 1);
        p = '{ACT_PKT, now, ETH_IPV4, pool_sa[k], pool_da[k], pool_pr[k],
              8'($urandom), 16'($urandom), pool_sp[k], pool_dp[k],
              8'($urandom) & ~FLAG_CLOSE, -1};
        case ($urandom_range(0, 19))
          0: p.eth_type = 16'($urandom);                   // noise
          1: p.protocol = 8'($urandom);
          2, 3: p.flags = 8'($urandom);                    // may close
          4: p.time_ms = $urandom;                         // jump anywhere
          5: p.time_ms = now - $urandom_range(0, 5000);    // backwards
          6: begin
            p.src_addr = $urandom;
            p.dst_addr = $urandom;
          end
          default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
          now = now + $urandom_range(0, 70000000);         // beyond any timeout
        else
          now = now + $urandom_range(0, 3000);
        if (it == 34) p.action = ACT_FLUSH;
        send_pkt(p);
      end
    end

    in_valid <= 1'b0;
    while (pending_exports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ netflow_flow_cache.f @@
+incdir+rtl
rtl/nfc_pkg.sv
rtl/nfc_ctrl.sv
rtl/nfc_dp.sv
rtl/netflow_flow_cache.sv
rtl/nfc_checker.sv
sim/netflow_flow_cache_tb.sv
